// ===== hw/rtl/rsps_pkg.sv =====
// shared types, constants and register codes for the rotated sprite pixel shader
package rsps_pkg;

  localparam int unsigned SCREEN_W = 1280;
  localparam int unsigned SCREEN_H = 1024;

  localparam int unsigned PIX_W    = 11;
  localparam int unsigned LEFT_W   = 12;
  localparam int unsigned TOP_W    = 11;
  localparam int unsigned TRIG_W   = 16;
  localparam int unsigned STYLE_W  = 3;
  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned OFS_W    = 7;   // window offset -46..45
  localparam int unsigned DIFF_W   = 14;  // full pixel minus centre range
  localparam int unsigned PROD_W   = OFS_W + TRIG_W;
  localparam int unsigned SUM_W    = PROD_W + 1;
  localparam int unsigned FRAC_W   = 14;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  localparam int signed HALF_SPRITE = 32;
  localparam int signed WINDOW_HALF = 46;
  localparam int signed CENTRE_BIAS = 532480;  // 32.5 in Q.14
  localparam int signed IDX_LIMIT   = 64 << FRAC_W;
  localparam int signed NEG_LIMIT   = -(1 << FRAC_W);

  // register indexes
  localparam logic [2:0] REG_LEFT  = 3'd0;
  localparam logic [2:0] REG_TOP   = 3'd1;
  localparam logic [2:0] REG_COS   = 3'd2;
  localparam logic [2:0] REG_SIN   = 3'd3;
  localparam logic [2:0] REG_STYLE = 3'd4;

  // pattern codes
  localparam logic [2:0] STYLE_SMILEY  = 3'd0;
  localparam logic [2:0] STYLE_CHEST   = 3'd1;
  localparam logic [2:0] STYLE_TARGET  = 3'd2;
  localparam logic [2:0] STYLE_DIAMOND = 3'd3;
  localparam logic [2:0] STYLE_STONE   = 3'd4;
  localparam logic [2:0] STYLE_RAINBOW = 3'd5;

  localparam logic [COLOR_W-1:0] C_BLACK   = 24'h000000;
  localparam logic [COLOR_W-1:0] C_WHITE   = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] C_BLUE_SM = 24'h0088FF;
  localparam logic [COLOR_W-1:0] C_SILVER  = 24'hC0C0C0;
  localparam logic [COLOR_W-1:0] C_BROWN   = 24'h8B4513;
  localparam logic [COLOR_W-1:0] C_MAGENTA = 24'hFF00FF;
  localparam logic [COLOR_W-1:0] C_CYAN    = 24'h00FFFF;
  localparam logic [COLOR_W-1:0] C_GRAY    = 24'h888888;
  localparam logic [COLOR_W-1:0] C_RED     = 24'hFF0000;
  localparam logic [COLOR_W-1:0] C_ORANGE  = 24'hFF8800;
  localparam logic [COLOR_W-1:0] C_YELLOW  = 24'hFFFF00;
  localparam logic [COLOR_W-1:0] C_GREEN   = 24'h00FF00;
  localparam logic [COLOR_W-1:0] C_BLUE    = 24'h0000FF;
  localparam logic [COLOR_W-1:0] C_PURPLE  = 24'h8800FF;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pix_t;

  typedef struct packed {
    logic               write_pixel;
    logic [COLOR_W-1:0] pixel_color;
  } shade_t;

endpackage

// ===== hw/rtl/rsps_color.sv =====
// procedural pattern lookup: sprite texel coordinate to 24-bit color
module rsps_color (
  input  logic [2:0]                    style,
  input  logic [rsps_pkg::IDX_W-1:0]    rx,
  input  logic [rsps_pkg::IDX_W-1:0]    ry,
  output logic [rsps_pkg::COLOR_W-1:0]  color
);

  logic       rim;
  logic [7:0] sx, sy;
  logic [7:0] ax, ay, d1, d2, t1, t2, t3;
  logic [6:0] dsum;
  logic [12:0] dprod;

  assign sx = {2'b00, rx};
  assign sy = {2'b00, ry};
  assign rim = (sx < 8'd4) || (sx > 8'd59) || (sy < 8'd4) || (sy > 8'd59);

  always_comb begin
    ax = (sx >= 8'd32) ? sx - 8'd32 : 8'd32 - sx;
    ay = (sy >= 8'd32) ? sy - 8'd32 : 8'd32 - sy;
    dsum = 7'(ax + ay);
    // d/6 by reciprocal, exact for d up to 64
    dprod = 13'(dsum) * 13'd43;
    t1 = (sx >= sy) ? sx - sy : sy - sx;
    d1 = t1;
    t2 = sx + sy;
    t3 = (t2 >= 8'd63) ? t2 - 8'd63 : 8'd63 - t2;
    d2 = t3;
  end

  always_comb begin
    color = rsps_pkg::C_BLACK;
    case (style)
      rsps_pkg::STYLE_SMILEY: begin
        if (rim) color = rsps_pkg::C_BLACK;
        else if (sx >= 8'd16 && sx <= 8'd24 && sy >= 8'd16 && sy <= 8'd28)
          color = rsps_pkg::C_BLACK;
        else if (sx >= 8'd39 && sx <= 8'd47 && sy >= 8'd16 && sy <= 8'd28)
          color = rsps_pkg::C_BLACK;
        else if (sx >= 8'd16 && sx <= 8'd47 && sy >= 8'd44 && sy <= 8'd48)
          color = rsps_pkg::C_BLACK;
        else if ((sx >= 8'd16 && sx <= 8'd20 && sy >= 8'd36 && sy <= 8'd44) ||
                 (sx >= 8'd43 && sx <= 8'd47 && sy >= 8'd36 && sy <= 8'd44))
          color = rsps_pkg::C_BLACK;
        else color = rsps_pkg::C_BLUE_SM;
      end
      rsps_pkg::STYLE_CHEST: begin
        if (rim) color = rsps_pkg::C_BLACK;
        else if (sy >= 8'd28 && sy <= 8'd32) color = rsps_pkg::C_BLACK;
        else if (sx >= 8'd24 && sx <= 8'd40 && sy >= 8'd20 && sy <= 8'd40) begin
          if (sx >= 8'd30 && sx <= 8'd34 && sy >= 8'd28 && sy <= 8'd36)
            color = rsps_pkg::C_BLACK;
          else color = rsps_pkg::C_SILVER;
        end
        else color = rsps_pkg::C_BROWN;
      end
      rsps_pkg::STYLE_TARGET: begin
        if (rim) color = rsps_pkg::C_BLACK;
        else if (sx < 8'd12 || sx > 8'd51 || sy < 8'd12 || sy > 8'd51)
          color = rsps_pkg::C_WHITE;
        else if (sx < 8'd20 || sx > 8'd43 || sy < 8'd20 || sy > 8'd43)
          color = rsps_pkg::C_RED;
        else if (sx < 8'd28 || sx > 8'd35 || sy < 8'd28 || sy > 8'd35)
          color = rsps_pkg::C_WHITE;
        else color = rsps_pkg::C_RED;
      end
      rsps_pkg::STYLE_DIAMOND: begin
        if (rim) color = rsps_pkg::C_BLACK;
        else if (!dprod[8]) color = rsps_pkg::C_MAGENTA;
        else color = rsps_pkg::C_CYAN;
      end
      rsps_pkg::STYLE_STONE: begin
        if (rim) color = rsps_pkg::C_BLACK;
        else if (d1 < 8'd3 && sx > 8'd20) color = rsps_pkg::C_BLACK;
        else if (d2 < 8'd2 && sy < 8'd40) color = rsps_pkg::C_BLACK;
        else if (sx >= 8'd28 && sx <= 8'd32 && sy >= 8'd32) color = rsps_pkg::C_BLACK;
        else color = rsps_pkg::C_GRAY;
      end
      rsps_pkg::STYLE_RAINBOW: begin
        if (rim) color = rsps_pkg::C_BLACK;
        else if (sy < 8'd14) color = rsps_pkg::C_RED;
        else if (sy < 8'd24) color = rsps_pkg::C_ORANGE;
        else if (sy < 8'd34) color = rsps_pkg::C_YELLOW;
        else if (sy < 8'd44) color = rsps_pkg::C_GREEN;
        else if (sy < 8'd54) color = rsps_pkg::C_BLUE;
        else color = rsps_pkg::C_PURPLE;
      end
      default: color = rsps_pkg::C_BLACK;
    endcase
  end

endmodule

// ===== hw/rtl/rotated_sprite_pixel_shader_unit.sv =====
// top level: register file and four-stage shading pipeline
// Takes one pixel coordinate per clock unless pix_stall is high, and returns one result per
// pixel, in order: write_pixel says whether the rotated 64x64 sprite covers the pixel and
// pixel_color gives its color (0 when not covered). Throughput is one pixel per clock while
// the result side does not stall; each result passes through the four register stages of
// window check, rotation multipliers, offset/index stage and pattern lookup. A stall on the
// result side freezes only the stages that are full, so bubbles are squeezed out.
// Registers sit at byte addresses 0 (left), 4 (top), 8 (cos), 12 (sin), 16 (style);
// write them only while no pixel is in flight.
module rotated_sprite_pixel_shader_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rsps_pkg::ADDR_W-1:0]   paddr,
  input  logic [rsps_pkg::DATA_W-1:0]   pwdata,
  output logic [rsps_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          pix_valid,
  output logic                          pix_stall,
  input  rsps_pkg::pix_t                pix,
  output logic                          shade_valid,
  input  logic                          shade_stall,
  output rsps_pkg::shade_t              shade
);

  // configuration
  logic signed [rsps_pkg::LEFT_W-1:0] sprite_left;
  logic signed [rsps_pkg::TOP_W-1:0]  sprite_top;
  logic signed [rsps_pkg::TRIG_W-1:0] cos_angle;
  logic signed [rsps_pkg::TRIG_W-1:0] sin_angle;
  logic        [rsps_pkg::STYLE_W-1:0] sprite_style;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_left  <= '0;
      sprite_top   <= '0;
      cos_angle    <= 16'sd16384;
      sin_angle    <= '0;
      sprite_style <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rsps_pkg::REG_LEFT:  sprite_left  <= pwdata[rsps_pkg::LEFT_W-1:0];
        rsps_pkg::REG_TOP:   sprite_top   <= pwdata[rsps_pkg::TOP_W-1:0];
        rsps_pkg::REG_COS:   cos_angle    <= pwdata[rsps_pkg::TRIG_W-1:0];
        rsps_pkg::REG_SIN:   sin_angle    <= pwdata[rsps_pkg::TRIG_W-1:0];
        rsps_pkg::REG_STYLE: sprite_style <= pwdata[rsps_pkg::STYLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rsps_pkg::REG_LEFT:  prdata = {20'b0, sprite_left};
      rsps_pkg::REG_TOP:   prdata = {21'b0, sprite_top};
      rsps_pkg::REG_COS:   prdata = {16'b0, cos_angle};
      rsps_pkg::REG_SIN:   prdata = {16'b0, sin_angle};
      rsps_pkg::REG_STYLE: prdata = {29'b0, sprite_style};
      default:             prdata = '0;
    endcase
  end

  // stage enables: a stage moves when it is empty or its successor moves
  logic en1, en2, en3, en4;
  logic v1, v2, v3;

  assign en4 = !shade_valid || !shade_stall;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pix_stall = !en1;

  // stage 1: offsets from the centre and window / screen check
  logic signed [rsps_pkg::DIFF_W-1:0] dx0, dy0;
  logic ok0;
  logic ok1;
  logic signed [rsps_pkg::OFS_W-1:0] dx1, dy1;

  always_comb begin
    dx0 = $signed({3'b000, pix.pixel_x}) - (rsps_pkg::DIFF_W'(sprite_left)
          + rsps_pkg::DIFF_W'(rsps_pkg::HALF_SPRITE));
    dy0 = $signed({3'b000, pix.pixel_y}) - (rsps_pkg::DIFF_W'(sprite_top)
          + rsps_pkg::DIFF_W'(rsps_pkg::HALF_SPRITE));
    ok0 = ({1'b0, pix.pixel_x} < 12'(rsps_pkg::SCREEN_W))
       && ({1'b0, pix.pixel_y} < 12'(rsps_pkg::SCREEN_H))
       && (dx0 >= -rsps_pkg::DIFF_W'(rsps_pkg::WINDOW_HALF))
       && (dx0 <   rsps_pkg::DIFF_W'(rsps_pkg::WINDOW_HALF))
       && (dy0 >= -rsps_pkg::DIFF_W'(rsps_pkg::WINDOW_HALF))
       && (dy0 <   rsps_pkg::DIFF_W'(rsps_pkg::WINDOW_HALF));
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en1) v1 <= pix_valid;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ok1 <= ok0;
      dx1 <= dx0[rsps_pkg::OFS_W-1:0];
      dy1 <= dy0[rsps_pkg::OFS_W-1:0];
    end
  end

  // stage 2: rotation products
  logic ok2;
  logic signed [rsps_pkg::PROD_W-1:0] pxc, pys, pyc, pxs;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en2) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      ok2 <= ok1;
      pxc <= rsps_pkg::PROD_W'(dx1) * rsps_pkg::PROD_W'(cos_angle);
      pys <= rsps_pkg::PROD_W'(dy1) * rsps_pkg::PROD_W'(sin_angle);
      pyc <= rsps_pkg::PROD_W'(dy1) * rsps_pkg::PROD_W'(cos_angle);
      pxs <= rsps_pkg::PROD_W'(dx1) * rsps_pkg::PROD_W'(sin_angle);
    end
  end

  // stage 3: bias, truncate toward zero, range check
  logic signed [rsps_pkg::SUM_W-1:0] su, sv;
  logic okx, oky;
  logic ok3;
  logic [rsps_pkg::IDX_W-1:0] rx3, ry3;

  always_comb begin
    su = rsps_pkg::SUM_W'(pxc) + rsps_pkg::SUM_W'(pys)
       + rsps_pkg::SUM_W'(rsps_pkg::CENTRE_BIAS);
    sv = rsps_pkg::SUM_W'(pyc) - rsps_pkg::SUM_W'(pxs)
       + rsps_pkg::SUM_W'(rsps_pkg::CENTRE_BIAS);
    okx = (su > rsps_pkg::SUM_W'(rsps_pkg::NEG_LIMIT))
       && (su < rsps_pkg::SUM_W'(rsps_pkg::IDX_LIMIT));
    oky = (sv > rsps_pkg::SUM_W'(rsps_pkg::NEG_LIMIT))
       && (sv < rsps_pkg::SUM_W'(rsps_pkg::IDX_LIMIT));
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en3) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      ok3 <= ok2 && okx && oky;
      // a sum in (-1,0) truncates to index zero
      rx3 <= su[rsps_pkg::SUM_W-1] ? '0
             : su[rsps_pkg::FRAC_W +: rsps_pkg::IDX_W];
      ry3 <= sv[rsps_pkg::SUM_W-1] ? '0
             : sv[rsps_pkg::FRAC_W +: rsps_pkg::IDX_W];
    end
  end

  // stage 4: pattern lookup into the result register
  logic [rsps_pkg::COLOR_W-1:0] color;

  rsps_color u_color (
    .style (sprite_style),
    .rx    (rx3),
    .ry    (ry3),
    .color (color)
  );

  always_ff @(posedge clk) begin
    if (rst) shade_valid <= 1'b0;
    else if (en4) shade_valid <= v3;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      shade.write_pixel <= ok3;
      shade.pixel_color <= ok3 ? color : '0;
    end
  end

  // input is held back only when every stage is occupied
  a_full_when_stalled: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> (v1 && v2 && v3 && shade_valid))
    else $error("input stalled with a bubble in the pipeline");

  a_color_zero: assert property (@(posedge clk) disable iff (rst)
    (shade_valid && !shade.write_pixel) |-> (shade.pixel_color == '0))
    else $error("uncovered pixel carries a color");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (v3 && shade_valid && shade_stall) |=> v3)
    else $error("stage 3 item lost under stall");

endmodule
